[rtl/core/gpio_controller_edge_irq_unit_assert.svh]
// assertion macros for the gpio edge interrupt unit, included by its register block
`ifndef GPIO_CONTROLLER_EDGE_IRQ_UNIT_ASSERT_SVH
`define GPIO_CONTROLLER_EDGE_IRQ_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked property, masked while reset is high
`define GPIO_EIRQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gpio_eirq assertion failed");

// checked property, evaluated during reset as well
`define GPIO_EIRQ_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("gpio_eirq assertion failed");

`else

`define GPIO_EIRQ_ASSERT(label, clk, rst, prop)
`define GPIO_EIRQ_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

[rtl/core/gpio_eirq_pkg.sv]
`timescale 1ns / 1ps

package gpio_eirq_pkg;

   localparam int DATA_W    = 32;
   localparam int KIND_W    = 2;
   localparam int INDEX_W   = 4;
   localparam int BANK_EN_W = 2;

   localparam int                DEF_NUM_PINS      = 32;
   localparam int                DEF_PINS_PER_BANK = 16;
   localparam logic [DATA_W-1:0] DEF_ID_VALUE      = 32'h0000_0000;

   typedef enum logic [KIND_W-1:0] {
      KIND_READ   = 2'd0,
      KIND_WRITE  = 2'd1,
      KIND_SAMPLE = 2'd2
   } kind_type;

   localparam logic [INDEX_W-1:0] REG_ID       = 4'd0;
   localparam logic [INDEX_W-1:0] REG_BANK_EN  = 4'd1;
   localparam logic [INDEX_W-1:0] REG_DIR      = 4'd2;
   localparam logic [INDEX_W-1:0] REG_SET_DATA = 4'd3;
   localparam logic [INDEX_W-1:0] REG_CLR_DATA = 4'd4;
   localparam logic [INDEX_W-1:0] REG_IN_DATA  = 4'd5;
   localparam logic [INDEX_W-1:0] REG_SET_RIS  = 4'd6;
   localparam logic [INDEX_W-1:0] REG_CLR_RIS  = 4'd7;
   localparam logic [INDEX_W-1:0] REG_SET_FAL  = 4'd8;
   localparam logic [INDEX_W-1:0] REG_CLR_FAL  = 4'd9;
   localparam logic [INDEX_W-1:0] REG_STATUS   = 4'd10;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [INDEX_W-1:0] reg_index;
      logic [DATA_W-1:0]  write_data;
      logic [DATA_W-1:0]  pad_levels;
   } item_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [DATA_W-1:0] drive_levels;
      logic [DATA_W-1:0] drive_enable;
      logic              irq_low_bank;
      logic              irq_high_bank;
   } result_type;

endpackage

[rtl/core/gpio_eirq_if.sv]
`timescale 1ns / 1ps

interface gpio_eirq_req_if import gpio_eirq_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [INDEX_W-1:0] reg_index;
   logic [DATA_W-1:0]  write_data;
   logic [DATA_W-1:0]  pad_levels;

   modport source (output valid, kind, reg_index, write_data, pad_levels, input ready);
   modport sink   (input valid, kind, reg_index, write_data, pad_levels, output ready);
endinterface

interface gpio_eirq_rsp_if import gpio_eirq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_data;
   logic [DATA_W-1:0] drive_levels;
   logic [DATA_W-1:0] drive_enable;
   logic              irq_low_bank;
   logic              irq_high_bank;

   modport source (output valid, read_data, drive_levels, drive_enable, irq_low_bank,
                   irq_high_bank, input ready);
   modport sink   (input valid, read_data, drive_levels, drive_enable, irq_low_bank,
                   irq_high_bank, output ready);
endinterface

[rtl/core/gpio_eirq_in_stage.sv]
`timescale 1ns / 1ps

module gpio_eirq_in_stage import gpio_eirq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   gpio_eirq_req_if.sink     req_chan,
   input  logic              take,
   output logic              item_valid,
   output item_type          item
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     accept;

   // refill in the same cycle the held item moves on
   assign req_chan.ready = !valid_ff || take;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.kind       <= req_chan.kind;
         item_ff.reg_index  <= req_chan.reg_index;
         item_ff.write_data <= req_chan.write_data;
         item_ff.pad_levels <= req_chan.pad_levels;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[rtl/core/gpio_eirq_regs.sv]
`timescale 1ns / 1ps
`include "gpio_controller_edge_irq_unit_assert.svh"

module gpio_eirq_regs import gpio_eirq_pkg::*; #(
   parameter int                NUM_PINS      = DEF_NUM_PINS,
   parameter int                PINS_PER_BANK = DEF_PINS_PER_BANK,
   parameter logic [DATA_W-1:0] ID_VALUE      = DEF_ID_VALUE
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  item_type   item,
   output result_type result
);

   localparam logic [DATA_W-1:0] AllOnes  = '1;
   localparam logic [DATA_W-1:0] PinMask  = AllOnes >> (DATA_W - NUM_PINS);
   localparam logic [DATA_W-1:0] BankOnes = AllOnes >> (DATA_W - PINS_PER_BANK);
   localparam logic [DATA_W-1:0] LowMask  = BankOnes & PinMask;
   localparam logic [DATA_W-1:0] HighMask =
      (PINS_PER_BANK >= DATA_W) ? '0 : ((BankOnes << PINS_PER_BANK) & PinMask);

   logic [DATA_W-1:0]    direction_ff, direction_in;
   logic [DATA_W-1:0]    out_levels_ff, out_levels_in;
   logic [DATA_W-1:0]    in_levels_ff, in_levels_in;
   logic [DATA_W-1:0]    rise_enable_ff, rise_enable_in;
   logic [DATA_W-1:0]    fall_enable_ff, fall_enable_in;
   logic [DATA_W-1:0]    pending_ff, pending_in;
   logic [BANK_EN_W-1:0] bank_en_ff, bank_en_in;

   logic [DATA_W-1:0] wr_pins;
   logic [DATA_W-1:0] now_pins;
   logic [DATA_W-1:0] edges;
   logic [DATA_W-1:0] rd_data;

   assign wr_pins  = item.write_data & PinMask;
   assign now_pins = item.pad_levels & PinMask;
   assign edges    = (~in_levels_ff & now_pins & rise_enable_ff)
                   | (in_levels_ff & ~now_pins & fall_enable_ff);

   always_comb begin
      case (item.reg_index)
         REG_ID:       rd_data = ID_VALUE;
         REG_BANK_EN:  rd_data = {{(DATA_W-BANK_EN_W){1'b0}}, bank_en_ff};
         REG_DIR:      rd_data = direction_ff;
         REG_SET_DATA: rd_data = out_levels_ff;
         REG_CLR_DATA: rd_data = out_levels_ff;
         REG_IN_DATA:  rd_data = in_levels_ff;
         REG_SET_RIS:  rd_data = rise_enable_ff;
         REG_CLR_RIS:  rd_data = rise_enable_ff;
         REG_SET_FAL:  rd_data = fall_enable_ff;
         REG_CLR_FAL:  rd_data = fall_enable_ff;
         REG_STATUS:   rd_data = pending_ff;
         default:      rd_data = '0;
      endcase
   end

   always_comb begin
      direction_in     = direction_ff;
      out_levels_in    = out_levels_ff;
      in_levels_in     = in_levels_ff;
      rise_enable_in   = rise_enable_ff;
      fall_enable_in   = fall_enable_ff;
      pending_in       = pending_ff;
      bank_en_in       = bank_en_ff;
      result.read_data = '0;
      case (kind_type'(item.kind))
         KIND_READ: begin
            result.read_data = rd_data;
         end
         KIND_WRITE: begin
            case (item.reg_index)
               REG_BANK_EN:  bank_en_in     = item.write_data[BANK_EN_W-1:0];
               REG_DIR:      direction_in   = wr_pins;
               REG_SET_DATA: out_levels_in  = out_levels_ff | wr_pins;
               REG_CLR_DATA: out_levels_in  = out_levels_ff & ~wr_pins;
               REG_SET_RIS:  rise_enable_in = rise_enable_ff | wr_pins;
               REG_CLR_RIS:  rise_enable_in = rise_enable_ff & ~wr_pins;
               REG_SET_FAL:  fall_enable_in = fall_enable_ff | wr_pins;
               REG_CLR_FAL:  fall_enable_in = fall_enable_ff & ~wr_pins;
               REG_STATUS:   pending_in     = pending_ff & ~wr_pins;
               default:      ;
            endcase
         end
         KIND_SAMPLE: begin
            pending_in   = pending_ff | edges;
            in_levels_in = now_pins;
         end
         default: ;
      endcase
      // outputs reflect the state after this item
      result.drive_levels  = out_levels_in;
      result.drive_enable  = ~direction_in & PinMask;
      result.irq_low_bank  = bank_en_in[0] && ((pending_in & LowMask) != '0);
      result.irq_high_bank = bank_en_in[1] && ((pending_in & HighMask) != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff   <= PinMask;
         out_levels_ff  <= '0;
         in_levels_ff   <= '0;
         rise_enable_ff <= '0;
         fall_enable_ff <= '0;
         pending_ff     <= '0;
         bank_en_ff     <= '0;
      end else if (advance) begin
         direction_ff   <= direction_in;
         out_levels_ff  <= out_levels_in;
         in_levels_ff   <= in_levels_in;
         rise_enable_ff <= rise_enable_in;
         fall_enable_ff <= fall_enable_in;
         pending_ff     <= pending_in;
         bank_en_ff     <= bank_en_in;
      end
   end

   // status bits only get set by a sample transfer
   `GPIO_EIRQ_ASSERT(a_pending_set_by_sample, clock, reset, !(advance && item.kind == KIND_SAMPLE) |=> ((pending_ff & ~$past(pending_ff)) == '0))

   `GPIO_EIRQ_ASSERT(a_dir_only_by_write, clock, reset, !(advance && item.kind == KIND_WRITE && item.reg_index == REG_DIR) |=> $stable(direction_ff))

   `GPIO_EIRQ_ASSERT(a_read_data_only_on_read, clock, reset, (item.kind != KIND_READ) |-> (result.read_data == '0))

   `GPIO_EIRQ_ASSERT(a_no_unimplemented_pins, clock, reset, ((pending_ff | in_levels_ff | out_levels_ff) & ~PinMask) == '0)

endmodule

[rtl/core/gpio_eirq_out_stage.sv]
`timescale 1ns / 1ps

module gpio_eirq_out_stage import gpio_eirq_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  result_type      result,
   output logic            can_take,
   gpio_eirq_rsp_if.source rsp_chan
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign can_take = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.read_data     = result_ff.read_data;
   assign rsp_chan.drive_levels  = result_ff.drive_levels;
   assign rsp_chan.drive_enable  = result_ff.drive_enable;
   assign rsp_chan.irq_low_bank  = result_ff.irq_low_bank;
   assign rsp_chan.irq_high_bank = result_ff.irq_high_bank;

endmodule

[rtl/core/gpio_controller_edge_irq_unit.sv]
`timescale 1ns / 1ps

// GPIO controller with edge interrupts, driven as a stream of bus reads, bus writes
// and pad sample ticks. Every transfer returns one result: the read data (zero for
// anything but a read), the output levels, the output enables and the two bank
// interrupt lines, all as they stand after that transfer. One transfer is taken per
// clock cycle as long as the response channel accepts results; each request is held
// in the request register and passes through the single-pass register update into
// the result register. Status bits are write-one-to-clear and are set only by
// enabled edges seen between consecutive samples.
module gpio_controller_edge_irq_unit import gpio_eirq_pkg::*; #(
   parameter int                NUM_PINS      = DEF_NUM_PINS,
   parameter int                PINS_PER_BANK = DEF_PINS_PER_BANK,
   parameter logic [DATA_W-1:0] ID_VALUE      = DEF_ID_VALUE
) (
   input logic             clock,
   input logic             reset,
   gpio_eirq_req_if.sink   req_chan,
   gpio_eirq_rsp_if.source rsp_chan
);

   logic       item_valid;
   item_type   item;
   logic       can_take;
   logic       advance;
   result_type result;

   assign advance = item_valid && can_take;

   gpio_eirq_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .take       (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   gpio_eirq_regs #(
      .NUM_PINS      (NUM_PINS),
      .PINS_PER_BANK (PINS_PER_BANK),
      .ID_VALUE      (ID_VALUE)
   ) u_regs (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .result  (result)
   );

   gpio_eirq_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .result   (result),
      .can_take (can_take),
      .rsp_chan (rsp_chan)
   );

endmodule
